FILE: rtl/core/trct_pkg.sv
// trct_pkg: shared types, register indexes, reset values and the segment length function
// for the tri-state remote code transmitter; no dependencies
package trct_pkg;

  localparam int unsigned CodeWidth     = 24;
  localparam int unsigned TickWidth     = 16;
  localparam int unsigned CodeSymbols   = CodeWidth / 2;
  localparam int unsigned SymbolsDefault = 12;
  localparam int unsigned RepeatsDefault = 4;

  localparam logic [CodeWidth-1:0] CodeWordReset   = 24'd68264;
  localparam logic [TickWidth-1:0] ShortHighReset  = 16'd250;
  localparam logic [TickWidth-1:0] LongHighReset   = 16'd810;
  localparam logic [TickWidth-1:0] ZeroLowReset    = 16'd690;
  localparam logic [TickWidth-1:0] OneLowReset     = 16'd210;
  localparam logic [TickWidth-1:0] FloatShortReset = 16'd700;
  localparam logic [TickWidth-1:0] FloatLongReset  = 16'd200;
  localparam logic [TickWidth-1:0] SyncLowReset    = 16'd7000;

  typedef enum logic [2:0] {
    RegCodeWord   = 3'd0,
    RegShortHigh  = 3'd1,
    RegLongHigh   = 3'd2,
    RegZeroLow    = 3'd3,
    RegOneLow     = 3'd4,
    RegFloatShort = 3'd5,
    RegFloatLong  = 3'd6,
    RegSyncLow    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SymZero   = 2'd0,
    SymOne    = 2'd1,
    SymFloatA = 2'd2,
    SymFloatB = 2'd3
  } sym_code_e;

  typedef struct packed {
    logic [CodeWidth-1:0] code_word;
    logic [TickWidth-1:0] short_high;
    logic [TickWidth-1:0] long_high;
    logic [TickWidth-1:0] zero_low;
    logic [TickWidth-1:0] one_low;
    logic [TickWidth-1:0] float_short_low;
    logic [TickWidth-1:0] float_long_low;
    logic [TickWidth-1:0] sync_low;
  } cfg_t;

  typedef struct packed {
    logic tx_level;
    logic busy;
  } res_t;

  function automatic logic [TickWidth-1:0] at_least_one(input logic [TickWidth-1:0] v);
    return (v == '0) ? TickWidth'(1) : v;
  endfunction

  // length of one segment: sync frame tail or segment seg of a symbol with code
  function automatic logic [TickWidth-1:0] seg_len(input cfg_t cfg, input logic is_sync,
                                                   input logic [1:0] code,
                                                   input logic [1:0] seg);
    logic [TickWidth-1:0] len;
    len = cfg.short_high;
    if (is_sync) begin
      len = (seg == 2'd0) ? cfg.short_high : cfg.sync_low;
    end else begin
      unique case (sym_code_e'(code))
        SymZero: len = seg[0] ? cfg.zero_low : cfg.short_high;
        SymOne:  len = seg[0] ? cfg.one_low : cfg.long_high;
        SymFloatA, SymFloatB: begin
          unique case (seg)
            2'd0: len = cfg.short_high;
            2'd1: len = cfg.float_short_low;
            2'd2: len = cfg.long_high;
            2'd3: len = cfg.float_long_low;
            default: len = cfg.short_high;
          endcase
        end
        default: len = cfg.short_high;
      endcase
    end
    return at_least_one(len);
  endfunction

endpackage

FILE: rtl/core/trct_cfg_regs.sv
// trct_cfg_regs: configuration register file, one write port, no read-back
// depends on trct_pkg
module trct_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  trct_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [trct_pkg::CodeWidth-1:0] cfg_data_i,
  output trct_pkg::cfg_t                 cfg_o
);
  import trct_pkg::*;

  cfg_t cfg_q;
  logic [TickWidth-1:0] v16;

  assign v16   = cfg_data_i[TickWidth-1:0];
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_word       <= CodeWordReset;
      cfg_q.short_high      <= ShortHighReset;
      cfg_q.long_high       <= LongHighReset;
      cfg_q.zero_low        <= ZeroLowReset;
      cfg_q.one_low         <= OneLowReset;
      cfg_q.float_short_low <= FloatShortReset;
      cfg_q.float_long_low  <= FloatLongReset;
      cfg_q.sync_low        <= SyncLowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCodeWord:   cfg_q.code_word       <= cfg_data_i;
        RegShortHigh:  cfg_q.short_high      <= v16;
        RegLongHigh:   cfg_q.long_high       <= v16;
        RegZeroLow:    cfg_q.zero_low        <= v16;
        RegOneLow:     cfg_q.one_low         <= v16;
        RegFloatShort: cfg_q.float_short_low <= v16;
        RegFloatLong:  cfg_q.float_long_low  <= v16;
        RegSyncLow:    cfg_q.sync_low        <= v16;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/trct_framer.sv
// trct_framer: burst, frame, symbol and segment counters with the tick timer
// depends on trct_pkg
module trct_framer #(
  parameter int unsigned SYMBOLS = trct_pkg::SymbolsDefault,
  parameter int unsigned REPEATS = trct_pkg::RepeatsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           start_i,
  input  trct_pkg::cfg_t cfg_i,
  output trct_pkg::res_t res_o
);
  import trct_pkg::*;

  localparam int unsigned SymW   = $clog2(SYMBOLS + 1);
  localparam int unsigned FrameW = (REPEATS > 1) ? $clog2(REPEATS) : 1;

  logic                 active_q, active_d;
  logic [TickWidth-1:0] ticks_q, ticks_d;
  logic [SymW-1:0]      sym_q, sym_d;
  logic [1:0]           seg_q, seg_d;
  logic [FrameW-1:0]    frame_q, frame_d;

  logic                 launch;
  logic                 act_e;
  logic [TickWidth-1:0] ticks_e;
  logic [SymW-1:0]      sym_e;
  logic [1:0]           seg_e;
  logic [FrameW-1:0]    frame_e;
  logic                 sync_e;
  logic [SymW-1:0]      sym_n;
  logic [1:0]           seg_n;
  logic                 sync_n;

  // symbol code from the code word; symbols past its end read as zero
  function automatic logic [1:0] code_of(input logic [CodeWidth-1:0] cw,
                                         input logic [SymW-1:0] s);
    logic [4:0] sx;
    sx = 5'(s);
    if (sx < 5'(CodeSymbols)) begin
      return cw[2*sx[3:0] +: 2];
    end
    return SymZero;
  endfunction

  assign launch  = !active_q && start_i;
  assign act_e   = active_q || start_i;
  assign sym_e   = launch ? '0 : sym_q;
  assign seg_e   = launch ? 2'd0 : seg_q;
  assign frame_e = launch ? '0 : frame_q;
  assign ticks_e = launch ? seg_len(cfg_i, 1'b0, code_of(cfg_i.code_word, '0), 2'd0)
                          : ticks_q;
  assign sync_e  = (sym_e == SymW'(SYMBOLS));

  always_comb begin
    active_d = active_q;
    ticks_d  = ticks_q;
    sym_d    = sym_q;
    seg_d    = seg_q;
    frame_d  = frame_q;
    sym_n    = sym_e;
    seg_n    = seg_e;
    sync_n   = sync_e;
    res_o    = '{tx_level: 1'b0, busy: 1'b0};
    if (act_e) begin
      res_o    = '{tx_level: ~seg_e[0], busy: 1'b1};
      active_d = 1'b1;
      sym_d    = sym_e;
      seg_d    = seg_e;
      frame_d  = frame_e;
      if (ticks_e > TickWidth'(1)) begin
        ticks_d = ticks_e - TickWidth'(1);
      end else begin
        // segment done: move to the next one
        if (seg_e != (sync_e ? 2'd1 : 2'd3)) begin
          seg_n = seg_e + 2'd1;
        end else begin
          seg_n = 2'd0;
          if (!sync_e) begin
            sym_n = sym_e + SymW'(1);
          end else begin
            sym_n = '0;
          end
        end
        sym_d  = sym_n;
        seg_d  = seg_n;
        sync_n = (sym_n == SymW'(SYMBOLS));
        if (sync_e && seg_e == 2'd1) begin
          if (frame_e == FrameW'(REPEATS - 1)) begin
            active_d = 1'b0;
            frame_d  = '0;
          end else begin
            frame_d = frame_e + FrameW'(1);
          end
        end
        ticks_d = active_d ? seg_len(cfg_i, sync_n, code_of(cfg_i.code_word, sym_n), seg_n)
                           : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ticks_q  <= '0;
      sym_q    <= '0;
      seg_q    <= '0;
      frame_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      ticks_q  <= ticks_d;
      sym_q    <= sym_d;
      seg_q    <= seg_d;
      frame_q  <= frame_d;
    end
  end

endmodule

FILE: rtl/core/trct_out_reg.sv
// trct_out_reg: result register between the framer and the output channel
// depends on trct_pkg
module trct_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  trct_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           full_o,
  output trct_pkg::res_t res_o
);
  import trct_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // full while a result waits and the receiver holds it off
  assign full_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign valid_d     = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/core/tristate_remote_code_transmitter.sv
// tristate_remote_code_transmitter: top level of the tri-state remote code encoder
// depends on trct_pkg, trct_cfg_regs, trct_framer, trct_out_reg
//
// Each input transfer is one tick of the pulse timebase carrying start_req_i.
// While idle a start launches a burst of REPEATS frames; each frame is SYMBOLS
// tri-state symbols from the code word followed by a sync pulse. Start requests
// during a burst are dropped. Every input transfer yields exactly one result
// transfer carrying tx_level_o (line level for that tick) and busy_res_o.
// The result of a tick is offered on the output channel in the cycle after its
// input transfer. Throughput is one tick per cycle unless the receiver stalls
// with a result waiting; the framer updates its counters on each accepted tick.
// When the receiver stalls with a result waiting, in_stall_o goes high and the
// counters hold; input is taken again in the cycle the waiting result leaves.
// Configuration writes are registered and apply from the next segment loaded.
// Reset clears the counters (idle, line low) and loads the default timings.
module tristate_remote_code_transmitter #(
  parameter int unsigned SYMBOLS = trct_pkg::SymbolsDefault,
  parameter int unsigned REPEATS = trct_pkg::RepeatsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           tx_level_o,
  output logic                           busy_res_o,
  input  logic                           cfg_we_i,
  input  trct_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [trct_pkg::CodeWidth-1:0] cfg_data_i
);
  import trct_pkg::*;

  cfg_t cfg;
  res_t res_new, res_out;
  logic in_xfer;
  logic full;

  assign in_stall_o = full;
  assign in_xfer    = in_valid_i && !full;
  assign tx_level_o = res_out.tx_level;
  assign busy_res_o = res_out.busy;

  trct_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  trct_framer #(
    .SYMBOLS (SYMBOLS),
    .REPEATS (REPEATS)
  ) u_framer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_xfer),
    .start_i (start_req_i),
    .cfg_i   (cfg),
    .res_o   (res_new)
  );

  trct_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .full_o      (full),
    .res_o       (res_out)
  );

  // an accepted tick always shows up as a result in the next cycle
  a_xfer_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("accepted tick produced no result");

  // input is only held off by a waiting result
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with room in the result register");

  // the line stays low outside a burst
  a_idle_line_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> !tx_level_o)
    else $error("line high while idle");

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for the tri-state remote code transmitter
// drives tick transfers, predicts line level and busy per tick, compares results
// depends on trct_pkg and tristate_remote_code_transmitter
`timescale 1ns / 100ps

module tb_top;
  import trct_pkg::*;

  localparam int unsigned SYMBOLS     = SymbolsDefault;
  localparam int unsigned REPEATS     = RepeatsDefault;
  localparam int unsigned HOLD_CYCLES = 300;
  // no transfer for this long means the block has hung; well above the hold-off
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  logic                 start_req = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic                 tx_level_o;
  logic                 busy_res_o;
  logic                 cfg_we = 1'b0;
  cfg_idx_e             cfg_idx = RegCodeWord;
  logic [CodeWidth-1:0] cfg_data = '0;

  tristate_remote_code_transmitter #(
    .SYMBOLS(SYMBOLS),
    .REPEATS(REPEATS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .start_req_i(start_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .tx_level_o (tx_level_o),
    .busy_res_o (busy_res_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // encoder state and register copy
  logic [CodeWidth-1:0] code_reg;
  logic [TickWidth-1:0] len_reg [8];
  logic                 enc_active;
  int unsigned          enc_ticks;
  int unsigned          enc_sym;
  logic [1:0]           enc_seg;
  int unsigned          enc_frame;

  logic        start_q [$];
  res_t        line_q [$];
  int unsigned ticks_queued = 0;
  int unsigned ticks_taken = 0;
  int unsigned mismatches = 0;
  int unsigned gap_pct = 10;
  int unsigned stall_pct = 10;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic void apply_reg(input cfg_idx_e idx, input logic [CodeWidth-1:0] data);
    if (idx == RegCodeWord) begin
      code_reg = data;
    end else begin
      len_reg[idx] = data[TickWidth-1:0];
    end
  endfunction

  function automatic int unsigned seg_ticks_now();
    logic [1:0]           sym;
    logic [TickWidth-1:0] v;
    if (enc_sym >= SYMBOLS) begin
      v = (enc_seg == 2'd0) ? len_reg[RegShortHigh] : len_reg[RegSyncLow];
    end else begin
      // symbols past the code word read as zeros
      sym = (enc_sym < CodeSymbols) ? code_reg[2*enc_sym +: 2] : SymZero;
      case (sym_code_e'(sym))
        SymZero: v = enc_seg[0] ? len_reg[RegZeroLow] : len_reg[RegShortHigh];
        SymOne:  v = enc_seg[0] ? len_reg[RegOneLow] : len_reg[RegLongHigh];
        default: begin
          case (enc_seg)
            2'd0:    v = len_reg[RegShortHigh];
            2'd1:    v = len_reg[RegFloatShort];
            2'd2:    v = len_reg[RegLongHigh];
            default: v = len_reg[RegFloatLong];
          endcase
        end
      endcase
    end
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic void next_segment();
    logic [1:0] last_seg;
    last_seg = (enc_sym >= SYMBOLS) ? 2'd1 : 2'd3;
    if (enc_seg < last_seg) begin
      enc_seg++;
    end else begin
      enc_seg = 2'd0;
      if (enc_sym < SYMBOLS) begin
        enc_sym++;
      end else begin
        enc_sym = 0;
        enc_frame++;
        if (enc_frame >= REPEATS) begin
          enc_frame  = 0;
          enc_active = 1'b0;
          enc_ticks  = 0;
          return;
        end
      end
    end
    enc_ticks = seg_ticks_now();
  endfunction

  function automatic res_t encode_tick(input logic start);
    res_t r;
    r = '0;
    if (!enc_active && start) begin
      enc_active = 1'b1;
      enc_frame  = 0;
      enc_sym    = 0;
      enc_seg    = 2'd0;
      enc_ticks  = seg_ticks_now();
    end
    if (enc_active) begin
      r.tx_level = ~enc_seg[0];
      r.busy     = 1'b1;
      if (enc_ticks > 0) enc_ticks--;
      if (enc_ticks == 0) next_segment();
    end
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      start_req <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        line_q.push_back(encode_tick(start_req));
        ticks_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (start_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          in_valid  <= 1'b1;
          start_req <= start_q.pop_front();
        end else begin
          in_valid  <= 1'b0;
          start_req <= 1'($urandom_range(1, 0));
        end
      end
    end
  end

  // receiver, with a one-off long hold-off when armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_line
    res_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (line_q.size() == 0) begin
        $display("%0t: unexpected transfer, tx_level %0b busy %0b", $time, tx_level_o,
                 busy_res_o);
        mismatches++;
      end else begin
        want = line_q.pop_front();
        if (tx_level_o !== want.tx_level) begin
          $display("%0t: tx_level expected %0b got %0b", $time, want.tx_level, tx_level_o);
          mismatches++;
        end
        if (busy_res_o !== want.busy) begin
          $display("%0t: busy expected %0b got %0b", $time, want.busy, busy_res_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic queue_ticks(input int unsigned n, input int unsigned start_pct);
    for (int unsigned i = 0; i < n; i++) begin
      start_q.push_back($urandom_range(99, 0) < start_pct);
      ticks_queued++;
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || line_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CodeWidth-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(RegCodeWord, c.code_word);
    write_reg(RegShortHigh, CodeWidth'(c.short_high));
    write_reg(RegLongHigh, CodeWidth'(c.long_high));
    write_reg(RegZeroLow, CodeWidth'(c.zero_low));
    write_reg(RegOneLow, CodeWidth'(c.one_low));
    write_reg(RegFloatShort, CodeWidth'(c.float_short_low));
    write_reg(RegFloatLong, CodeWidth'(c.float_long_low));
    write_reg(RegSyncLow, CodeWidth'(c.sync_low));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // keep ticking with no start until the current burst is over
  task automatic finish_burst();
    while (enc_active) begin
      queue_ticks(32, 0);
      drain();
    end
  endtask

  function automatic cfg_t random_cfg(input int unsigned lim);
    cfg_t c;
    case ($urandom_range(5, 0))
      0:       c.code_word = '0;
      1:       c.code_word = 24'hFFFFFF;
      2:       c.code_word = 24'h555555;
      default: c.code_word = CodeWidth'($urandom);
    endcase
    c.short_high      = TickWidth'($urandom_range(lim, 0));
    c.long_high       = TickWidth'($urandom_range(lim, 0));
    c.zero_low        = TickWidth'($urandom_range(lim, 0));
    c.one_low         = TickWidth'($urandom_range(lim, 0));
    c.float_short_low = TickWidth'($urandom_range(lim, 0));
    c.float_long_low  = TickWidth'($urandom_range(lim, 0));
    c.sync_low        = TickWidth'($urandom_range(lim, 0));
    return c;
  endfunction

  initial begin
    cfg_t c;
    code_reg                = CodeWordReset;
    len_reg[RegCodeWord]    = '0;
    len_reg[RegShortHigh]   = ShortHighReset;
    len_reg[RegLongHigh]    = LongHighReset;
    len_reg[RegZeroLow]     = ZeroLowReset;
    len_reg[RegOneLow]      = OneLowReset;
    len_reg[RegFloatShort]  = FloatShortReset;
    len_reg[RegFloatLong]   = FloatLongReset;
    len_reg[RegSyncLow]     = SyncLowReset;
    enc_active = 1'b0;
    enc_ticks  = 0;
    enc_sym    = 0;
    enc_seg    = 2'd0;
    enc_frame  = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle line, then a burst on reset timings with starts landing while busy
    queue_ticks(3, 0);
    queue_ticks(1, 100);
    queue_ticks(8, 30);
    drain();

    // short timings written mid-burst, one float-short gap of zero length
    c = '{code_word: 24'hE4E4E4, short_high: 16'd1, long_high: 16'd3, zero_low: 16'd2,
          one_low: 16'd1, float_short_low: 16'd0, float_long_low: 16'd2, sync_low: 16'd3};
    program_regs(c);
    finish_burst();

    // back-to-back bursts: a start on the first idle tick must relaunch
    queue_ticks(360, 100);
    drain();

    // every length zero, all floats
    c = '{code_word: 24'hFFFFFF, default: '0};
    program_regs(c);
    queue_ticks(200, 100);
    drain();
    finish_burst();

    for (int unsigned p = 0; p < 6; p++) begin
      program_regs(random_cfg((p % 2 == 0) ? 3 : 12));
      gap_pct   = (p == 2) ? 0 : 10;
      stall_pct = (p == 2) ? 0 : 10;
      if (p == 3) hold_armed = 1'b1;
      case (p % 3)
        0:       queue_ticks(60, 100);
        1:       queue_ticks(60, 40);
        default: queue_ticks(60, 3);
      endcase
      drain();
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/trct_pkg.sv
rtl/core/trct_cfg_regs.sv
rtl/core/trct_framer.sv
rtl/core/trct_out_reg.sv
rtl/core/tristate_remote_code_transmitter.sv
test/tb_top.sv
